[hdl/wgl_pkg.sv]
// Package with the shared constants, types and register codes of the guidance law core.
`default_nettype none
package wgl_pkg;

  localparam logic [15:0] WGL_CRUISE_SPEED = 16'd5120;
  localparam logic [15:0] WGL_MAX_SPEED    = 16'd10240;

  localparam logic signed [17:0] ANG_PI   = 18'sd25736;
  localparam logic signed [17:0] ANG_2PI  = 18'sd51472;
  localparam logic signed [17:0] ANG_177  = 18'sd25307;

  // Quotient bits resolved by the divider and restoring steps per stage.
  // Sixteen bits cover any speed limit that fits the 16-bit speed format.
  localparam int DIV_Q_W    = 16;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = DIV_Q_W / DIV_STEPS;

  // Reciprocal of ten for operands below 2^22: floor(x * RECIP10 / 2^23).
  localparam logic [19:0] RECIP10 = 20'd838861;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_BAND        = 3'd0,
    REG_GAIN_CROSS_TRACK = 3'd1,
    REG_GAIN_HEADING     = 3'd2,
    REG_ROLL_LIMIT       = 3'd3,
    REG_GAIN_HEIGHT      = 3'd4,
    REG_GAIN_BANK        = 3'd5,
    REG_PITCH_LIMIT      = 3'd6,
    REG_PITCH_BALANCE    = 3'd7
  } cfg_reg_e;

  // Results that travel alongside the divider.
  typedef struct packed {
    logic signed [14:0] roll;
    logic signed [15:0] pitch;
    logic [15:0]        speed_direct;
    logic               time_mode;
    logic               div_sat;
  } side_t;

endpackage
`default_nettype wire

[hdl/wgl_div.sv]
// Pipelined restoring divider for the time-to-go speed, two quotient bits per stage.
`default_nettype none
module wgl_div
  import wgl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [31:0]        dividend_i,
  input  wire logic [31:0]        divisor_i,
  input  wire side_t              side_i,
  output logic                    valid_o,
  output logic [DIV_Q_W-1:0]      quot_o,
  output side_t                   side_o
);

  logic               v_q [DIV_STAGES];
  logic [31:0]        r_q [DIV_STAGES];
  logic [31:0]        d_q [DIV_STAGES];
  logic [DIV_Q_W-1:0] q_q [DIV_STAGES];
  side_t              s_q [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic               v_in;
    logic [31:0]        r_in, d_in;
    logic [DIV_Q_W-1:0] q_in;
    side_t              s_in;
    logic [31:0]        r_d;
    logic [DIV_Q_W-1:0] q_d;

    if (g == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = dividend_i;
      assign d_in = divisor_i;
      assign q_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[g-1];
      assign r_in = r_q[g-1];
      assign d_in = d_q[g-1];
      assign q_in = q_q[g-1];
      assign s_in = s_q[g-1];
    end

    // The remainder stays below divisor << (bit + 1) unless the quotient saturated.
    always_comb begin
      logic [DIV_Q_W+31:0] sh;
      int                  idx;
      r_d = r_in;
      q_d = q_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
        idx = DIV_Q_W - 1 - g * DIV_STEPS - k;
        sh  = {{DIV_Q_W{1'b0}}, d_in} << idx;
        if ({{DIV_Q_W{1'b0}}, r_d} >= sh) begin
          r_d = r_d - sh[31:0];
          q_d = q_d | (DIV_Q_W'(1) << idx);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[g] <= r_d;
        d_q[g] <= d_in;
        q_q[g] <= q_d;
        s_q[g] <= s_in;
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign quot_o  = q_q[DIV_STAGES-1];
  assign side_o  = s_q[DIV_STAGES-1];

endmodule
`default_nettype wire

[hdl/waypoint_guidance_law_core.sv]
// Top level of the waypoint guidance law core: roll, pitch and speed targets per sample.
// One navigation sample enters per clock while in_stall_o is low; its targets pass through
// four stages of multiplies and rounding, the 8-stage speed divider that resolves two
// quotient bits per stage, and the output register. The whole pipeline holds while a
// result waits under out_stall_i, and in_stall_o is raised for exactly those cycles.
// Registers are written through the configuration port, which is always ready; the user
// is to write them only while the core is idle, and the block itself does not enforce it.
`default_nettype none
module waypoint_guidance_law_core
  import wgl_pkg::*;
#(
  parameter logic [15:0] CRUISE_SPEED = WGL_CRUISE_SPEED,
  parameter logic [15:0] MAX_SPEED    = WGL_MAX_SPEED
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic signed [23:0]   cross_track_error_i,
  input  wire logic signed [23:0]   height_error_i,
  input  wire logic signed [16:0]   yaw_angle_i,
  input  wire logic [15:0]          line_heading_i,
  input  wire logic signed [15:0]   roll_angle_i,
  input  wire logic [31:0]          speed_word_i,
  input  wire logic [31:0]          utc_seconds_i,
  input  wire logic [31:0]          waypoint_distance_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [14:0]        roll_target_o,
  output logic signed [15:0]        pitch_target_o,
  output logic [15:0]               speed_target_o
);

  // Configuration registers.
  logic [22:0]        dead_band_q;
  logic signed [15:0] gain_ct_q, gain_hd_q, gain_ht_q, gain_bk_q;
  logic [13:0]        roll_limit_q, pitch_limit_q;
  logic signed [14:0] pitch_bal_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_band_q   <= '0;
      gain_ct_q     <= '0;
      gain_hd_q     <= '0;
      roll_limit_q  <= '0;
      gain_ht_q     <= '0;
      gain_bk_q     <= '0;
      pitch_limit_q <= '0;
      pitch_bal_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_DEAD_BAND:        dead_band_q   <= cfg_data_i[22:0];
        REG_GAIN_CROSS_TRACK: gain_ct_q     <= cfg_data_i[15:0];
        REG_GAIN_HEADING:     gain_hd_q     <= cfg_data_i[15:0];
        REG_ROLL_LIMIT:       roll_limit_q  <= cfg_data_i[13:0];
        REG_GAIN_HEIGHT:      gain_ht_q     <= cfg_data_i[15:0];
        REG_GAIN_BANK:        gain_bk_q     <= cfg_data_i[15:0];
        REG_PITCH_LIMIT:      pitch_limit_q <= cfg_data_i[13:0];
        REG_PITCH_BALANCE:    pitch_bal_q   <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Stage 1: heading error wrap, products, speed operands.
  logic [23:0]        axte;
  logic signed [17:0] dw;
  logic signed [15:0] hd_err;
  logic signed [39:0] s1_pc_d;
  logic signed [31:0] s1_ph_d;
  logic signed [31:0] s1_rr_d;
  logic signed [39:0] s1_hp_d;

  always_comb begin
    axte = cross_track_error_i[23] ? 24'(-cross_track_error_i) : 24'(cross_track_error_i);
    dw   = 18'(yaw_angle_i) - $signed({2'b00, line_heading_i});
    if (dw > ANG_PI) begin
      dw = dw - ANG_2PI;
    end
    if (dw < -ANG_PI) begin
      dw = dw + ANG_2PI;
    end
    if (dw > ANG_177 || dw < -ANG_177) begin
      dw = ANG_PI;
    end
    hd_err  = dw[15:0];
    s1_pc_d = gain_ct_q * cross_track_error_i;
    s1_ph_d = gain_hd_q * hd_err;
    s1_rr_d = roll_angle_i * roll_angle_i;
    s1_hp_d = gain_ht_q * height_error_i;
  end

  logic               s1_v_q, s1_on_q, s1_mode_q, s1_big_q;
  logic signed [39:0] s1_pc_q, s1_hp_q;
  logic signed [31:0] s1_ph_q, s1_rr_q;
  logic [19:0]        s1_x_q;
  logic [31:0]        s1_div_q, s1_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_on_q   <= axte > {1'b0, dead_band_q};
      s1_pc_q   <= s1_pc_d;
      s1_ph_q   <= s1_ph_d;
      s1_rr_q   <= s1_rr_d;
      s1_hp_q   <= s1_hp_d;
      s1_mode_q <= speed_word_i[31];
      s1_big_q  <= speed_word_i[30:0] >= 31'd2560;
      s1_x_q    <= {speed_word_i[11:0], 8'd5};
      s1_div_q  <= {1'b0, speed_word_i[30:0]} - utc_seconds_i;
      s1_dist_q <= waypoint_distance_i;
    end
  end

  // Stage 2: roll rounding and clamp, bank product, tenths scaling, divider range check.
  logic signed [45:0] roll_sum;
  logic signed [33:0] roll_rnd, roll_cap;
  logic signed [14:0] s2_roll_d;

  always_comb begin
    roll_sum = (46'(s1_pc_q) <<< 5) + 46'(s1_ph_q) + 46'sd2048;
    roll_rnd = 34'(roll_sum >>> 12);
    roll_cap = $signed({20'd0, roll_limit_q});
    if (!s1_on_q) begin
      s2_roll_d = '0;
    end else if (roll_rnd > roll_cap) begin
      s2_roll_d = roll_cap[14:0];
    end else if (roll_rnd < -roll_cap) begin
      s2_roll_d = 15'(-roll_cap);
    end else begin
      s2_roll_d = roll_rnd[14:0];
    end
  end

  logic               s2_v_q, s2_mode_q, s2_big_q, s2_sat_q;
  logic signed [14:0] s2_roll_q;
  logic signed [47:0] s2_bp_q;
  logic signed [39:0] s2_hp_q;
  logic [39:0]        s2_xm_q;
  logic [31:0]        s2_div_q, s2_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_roll_q <= s2_roll_d;
      s2_bp_q   <= gain_bk_q * s1_rr_q;
      s2_hp_q   <= s1_hp_q;
      s2_xm_q   <= s1_x_q * RECIP10;
      s2_mode_q <= s1_mode_q;
      s2_big_q  <= s1_big_q;
      // A zero divisor also lands here and gives the maximum speed.
      s2_sat_q  <= (s1_dist_q >> DIV_Q_W) >= s1_div_q;
      s2_div_q  <= s1_div_q;
      s2_dist_q <= s1_dist_q;
    end
  end

  // Stage 3: pitch sum and rounding, direct speed.
  logic signed [58:0] pitch_sum;
  assign pitch_sum = (59'(s2_hp_q) <<< 18) + 59'(s2_bp_q) + 59'sd16777216;

  logic               s3_v_q, s3_mode_q, s3_sat_q;
  logic signed [14:0] s3_roll_q;
  logic signed [33:0] s3_prnd_q;
  logic [15:0]        s3_spd_q;
  logic [31:0]        s3_div_q, s3_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_roll_q <= s2_roll_q;
      s3_prnd_q <= 34'(pitch_sum >>> 25);
      s3_spd_q  <= s2_big_q ? 16'hFFFF : s2_xm_q[38:23];
      s3_mode_q <= s2_mode_q;
      s3_sat_q  <= s2_sat_q;
      s3_div_q  <= s2_div_q;
      s3_dist_q <= s2_dist_q;
    end
  end

  // Stage 4: pitch clamp and trim.
  logic signed [33:0] pitch_cap, pitch_cl;
  logic signed [15:0] pitch_d;

  always_comb begin
    pitch_cap = $signed({20'd0, pitch_limit_q});
    if (s3_prnd_q > pitch_cap) begin
      pitch_cl = pitch_cap;
    end else if (s3_prnd_q < -pitch_cap) begin
      pitch_cl = -pitch_cap;
    end else begin
      pitch_cl = s3_prnd_q;
    end
    pitch_d = pitch_cl[15:0] + 16'(pitch_bal_q);
  end

  logic        s4_v_q;
  side_t       s4_side_q;
  logic [31:0] s4_div_q, s4_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_side_q.roll         <= s3_roll_q;
      s4_side_q.pitch        <= pitch_d;
      s4_side_q.speed_direct <= s3_spd_q;
      s4_side_q.time_mode    <= s3_mode_q;
      s4_side_q.div_sat      <= s3_sat_q;
      s4_div_q               <= s3_div_q;
      s4_dist_q              <= s3_dist_q;
    end
  end

  logic               dv_valid;
  logic [DIV_Q_W-1:0] dv_quot;
  side_t              dv_side;

  wgl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s4_v_q),
    .dividend_i (s4_dist_q),
    .divisor_i  (s4_div_q),
    .side_i     (s4_side_q),
    .valid_o    (dv_valid),
    .quot_o     (dv_quot),
    .side_o     (dv_side)
  );

  // Output stage: time-mode clamp and result register.
  logic [15:0] quot_w, time_spd, speed_d;

  always_comb begin
    quot_w = 16'(dv_quot);
    if (dv_side.div_sat) begin
      time_spd = MAX_SPEED;
    end else begin
      time_spd = (quot_w < CRUISE_SPEED) ? CRUISE_SPEED : quot_w;
      if (time_spd > MAX_SPEED) begin
        time_spd = MAX_SPEED;
      end
    end
    speed_d = dv_side.time_mode ? time_spd : dv_side.speed_direct;
  end

  logic               out_v_q, out_mode_q;
  logic signed [14:0] out_roll_q;
  logic signed [15:0] out_pitch_q;
  logic [15:0]        out_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_roll_q  <= dv_side.roll;
      out_pitch_q <= dv_side.pitch;
      out_speed_q <= speed_d;
      out_mode_q  <= dv_side.time_mode;
    end
  end

  assign out_valid_o    = out_v_q;
  assign roll_target_o  = out_roll_q;
  assign pitch_target_o = out_pitch_q;
  assign speed_target_o = out_speed_q;

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(speed_target_o))
    else $error("result lost while stalled");

  a_roll_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (roll_target_o <= $signed({1'b0, roll_limit_q}))
                 && (roll_target_o >= -$signed({1'b0, roll_limit_q})))
    else $error("roll target beyond roll limit");

  a_time_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_mode_q |-> (speed_target_o <= MAX_SPEED)
                 && (speed_target_o >= CRUISE_SPEED || CRUISE_SPEED > MAX_SPEED))
    else $error("time-mode speed outside cruise and maximum");

endmodule
`default_nettype wire

[dv/waypoint_guidance_law_checker.sv]
// Checker for the guidance law core: predicts roll, pitch and speed targets and compares them.
`default_nettype none
module waypoint_guidance_law_checker
  import wgl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic                 cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_i,
  input  wire logic signed [23:0]   cross_track_error_i,
  input  wire logic signed [23:0]   height_error_i,
  input  wire logic signed [16:0]   yaw_angle_i,
  input  wire logic [15:0]          line_heading_i,
  input  wire logic signed [15:0]   roll_angle_i,
  input  wire logic [31:0]          speed_word_i,
  input  wire logic [31:0]          utc_seconds_i,
  input  wire logic [31:0]          waypoint_distance_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_stall_i,
  input  wire logic signed [14:0]   roll_target_i,
  input  wire logic signed [15:0]   pitch_target_i,
  input  wire logic [15:0]          speed_target_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [14:0] roll;
    logic [15:0] pitch;
    logic [15:0] speed;
  } targets_t;

  targets_t expected_targets[$];

  longint dead_band_q, gain_xt_q, gain_hdg_q, roll_cap_q;
  longint gain_hgt_q, gain_bank_q, pitch_cap_q, balance_q;

  initial begin
    fail_count_o = 0;
    checked_o    = 0;
  end

  assign pending_o = expected_targets.size();

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic targets_t predict_targets();
    targets_t t;
    longint xte, herr, yaw, hdg, roll, d, roll_t, pitch_t, acc;
    longint unsigned speed, tenths;
    logic [31:0] divisor;
    xte    = cross_track_error_i;
    herr   = height_error_i;
    yaw    = yaw_angle_i;
    hdg    = line_heading_i;
    roll   = roll_angle_i;
    roll_t = 0;
    if ((xte < 0 ? -xte : xte) > dead_band_q) begin
      d = yaw - hdg;
      // The heading error is wrapped by one turn at most.
      if (d > ANG_PI) d = d - ANG_2PI;
      if (d < -ANG_PI) d = d + ANG_2PI;
      if (d > ANG_177 || d < -ANG_177) d = ANG_PI;
      acc    = gain_xt_q * xte * 32 + gain_hdg_q * d;
      roll_t = clamp_sym((acc + 2048) >>> 12, roll_cap_q);
    end
    acc     = gain_hgt_q * herr * 262144 + gain_bank_q * (roll * roll);
    pitch_t = clamp_sym((acc + (64'sd1 <<< 24)) >>> 25, pitch_cap_q) + balance_q;
    if (!speed_word_i[31]) begin
      tenths = speed_word_i[30:0];
      speed  = (tenths * 256 + 5) / 10;
      if (speed > 65535) speed = 65535;
    end else begin
      divisor = {1'b0, speed_word_i[30:0]} - utc_seconds_i;
      if (divisor == 0) begin
        speed = WGL_MAX_SPEED;
      end else begin
        speed = waypoint_distance_i / divisor;
        if (speed < WGL_CRUISE_SPEED) speed = WGL_CRUISE_SPEED;
        if (speed > WGL_MAX_SPEED) speed = WGL_MAX_SPEED;
      end
    end
    t.roll  = roll_t[14:0];
    t.pitch = pitch_t[15:0];
    t.speed = speed[15:0];
    return t;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    targets_t want;
    if (!rst_ni) begin
      dead_band_q = 0; gain_xt_q = 0; gain_hdg_q = 0; roll_cap_q = 0;
      gain_hgt_q = 0; gain_bank_q = 0; pitch_cap_q = 0; balance_q = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_DEAD_BAND:        dead_band_q = cfg_data_i[22:0];
          REG_GAIN_CROSS_TRACK: gain_xt_q   = $signed(cfg_data_i[15:0]);
          REG_GAIN_HEADING:     gain_hdg_q  = $signed(cfg_data_i[15:0]);
          REG_ROLL_LIMIT:       roll_cap_q  = cfg_data_i[13:0];
          REG_GAIN_HEIGHT:      gain_hgt_q  = $signed(cfg_data_i[15:0]);
          REG_GAIN_BANK:        gain_bank_q = $signed(cfg_data_i[15:0]);
          REG_PITCH_LIMIT:      pitch_cap_q = cfg_data_i[13:0];
          REG_PITCH_BALANCE:    balance_q   = $signed(cfg_data_i[14:0]);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_targets.push_back(predict_targets());
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (expected_targets.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_targets.pop_front();
          if (roll_target_i !== want.roll)
            report_mismatch("roll_target", $signed(roll_target_i), $signed(want.roll));
          if (pitch_target_i !== want.pitch)
            report_mismatch("pitch_target", $signed(pitch_target_i), $signed(want.pitch));
          if (speed_target_i !== want.speed)
            report_mismatch("speed_target", speed_target_i, want.speed);
        end
      end
    end
  end

endmodule
`default_nettype wire

[dv/tb_waypoint_guidance_law_core.sv]
// Testbench top for the guidance law core: stimulus, register settings and the verdict.
`default_nettype none
module tb_waypoint_guidance_law_core
  import wgl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct {
    logic signed [23:0] xte;
    logic signed [23:0] herr;
    logic signed [16:0] yaw;
    logic [15:0]        hdg;
    logic signed [15:0] roll;
    logic [31:0]        word;
    logic [31:0]        now;
    logic [31:0]        wp_dist;
  } nav_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] xte = '0, herr = '0;
  logic signed [16:0] yaw = '0;
  logic [15:0] hdg = '0;
  logic signed [15:0] roll = '0;
  logic [31:0] word = '0, now = '0, wp_dist = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [14:0] roll_t;
  logic signed [15:0] pitch_t;
  logic [15:0] speed_t;

  int fail_count, pending, checked;
  int samples_sent = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int stall_mode = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  waypoint_guidance_law_core u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cross_track_error_i(xte), .height_error_i(herr), .yaw_angle_i(yaw),
    .line_heading_i(hdg), .roll_angle_i(roll), .speed_word_i(word),
    .utc_seconds_i(now), .waypoint_distance_i(wp_dist),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .roll_target_o(roll_t), .pitch_target_o(pitch_t), .speed_target_o(speed_t)
  );

  waypoint_guidance_law_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .cross_track_error_i(xte), .height_error_i(herr), .yaw_angle_i(yaw),
    .line_heading_i(hdg), .roll_angle_i(roll), .speed_word_i(word),
    .utc_seconds_i(now), .waypoint_distance_i(wp_dist),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .roll_target_i(roll_t), .pitch_target_i(pitch_t), .speed_target_i(speed_t),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // The receiver switches between free flow, light, heavy and solid stall stretches.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(1, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= 1'b1;
      default: out_stall <= $urandom_range(0, 1);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_sample(input nav_sample_t s);
    xte <= s.xte; herr <= s.herr; yaw <= s.yaw; hdg <= s.hdg;
    roll <= s.roll; word <= s.word; now <= s.now; wp_dist <= s.wp_dist;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // Drop the request and let the pipeline empty before anything else happens.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] value, input int w);
    logic [31:0] junk;
    junk = $urandom;
    cfg_index <= idx;
    cfg_data  <= (junk << w) | (value & ((32'd1 << w) - 1));
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic int rand_signed(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic apply_setting(input int k);
    int v[8];
    case (k)
      0: v = '{256, 4096, 8192, 12868, 2048, -4096, 12868, 300};
      1: v = '{0, 32767, 32767, 12868, 32767, 32767, 12868, 12868};
      2: v = '{8388607, -32768, -32768, 0, -32768, -32768, 0, -12868};
      3: v = '{1, -32768, 32767, 12868, -32768, 32767, 12868, 0};
      default: v = '{$urandom_range(0, 4096), rand_signed(-32768, 32767),
                     rand_signed(-32768, 32767), $urandom_range(0, 12868),
                     rand_signed(-32768, 32767), rand_signed(-32768, 32767),
                     $urandom_range(0, 12868), rand_signed(-12868, 12868)};
    endcase
    write_reg(REG_DEAD_BAND, v[0], 23);
    write_reg(REG_GAIN_CROSS_TRACK, v[1], 16);
    write_reg(REG_GAIN_HEADING, v[2], 16);
    write_reg(REG_ROLL_LIMIT, v[3], 14);
    write_reg(REG_GAIN_HEIGHT, v[4], 16);
    write_reg(REG_GAIN_BANK, v[5], 16);
    write_reg(REG_PITCH_LIMIT, v[6], 14);
    write_reg(REG_PITCH_BALANCE, v[7], 15);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic nav_sample_t rand_sample();
    nav_sample_t s;
    s.xte  = ($urandom_range(0, 2) == 0) ? 24'($urandom) : 24'(rand_signed(-8000, 8000));
    s.herr = ($urandom_range(0, 2) == 0) ? 24'($urandom) : 24'(rand_signed(-20000, 20000));
    s.yaw  = 17'(rand_signed(-51472, 51471));
    s.hdg  = 16'($urandom_range(0, 51471));
    s.roll = 16'(rand_signed(-25736, 25736));
    s.now  = $urandom;
    s.wp_dist = $urandom;
    case ($urandom_range(0, 3))
      0: s.word = {1'b0, 31'($urandom)};
      1: s.word = {1'b0, 31'($urandom_range(0, 3000))};
      2: s.word = {1'b1, 31'(s.now + $urandom_range(0, 2000))};
      default: s.word = {1'b1, 31'($urandom)};
    endcase
    if ($urandom_range(0, 3) == 0)
      s.wp_dist = $urandom_range(0, 4000) * (s.word[30:0] - s.now);
    return s;
  endfunction

  function automatic nav_sample_t directed_sample(input int k);
    nav_sample_t s;
    s = '{24'sd1000, 24'sd500, 17'sd100, 16'd0, 16'sd0, 32'd500, 32'd0, 32'd0};
    case (k)
      0:  s.xte = 24'sd8388607;
      1:  s.xte = -24'sd8388608;
      2:  s.xte = 24'sd256;                            // on the dead band edge
      3:  s.xte = -24'sd257;
      4:  begin s.yaw = 17'sd51471; s.hdg = 16'd0; end // wraps down once
      5:  begin s.yaw = -17'sd51472; s.hdg = 16'd51471; end
      6:  begin s.yaw = 17'sd25307; s.hdg = 16'd0; end
      7:  begin s.yaw = 17'sd25308; s.hdg = 16'd0; end // forced to pi
      8:  begin s.yaw = -17'sd25308; s.hdg = 16'd0; end
      9:  begin s.herr = 24'sd8388607; s.roll = 16'sd25736; end
      10: begin s.herr = -24'sd8388608; s.roll = -16'sd25736; end
      11: s.word = 32'd0;
      12: s.word = 32'h7FFF_FFFF;
      13: s.word = 32'd2560;
      14: s.word = 32'd2559;
      15: begin s.word = 32'h8000_1000; s.now = 32'h1000; end  // zero time to go
      16: begin s.word = 32'h8000_0010; s.now = 32'h1000; s.wp_dist = 32'hFFFF_FFFF; end
      17: begin s.word = 32'h8000_0100; s.now = 32'h10; s.wp_dist = 32'hFFFF_FFFF; end
      18: begin s.word = 32'h8000_0100; s.now = 32'h10; s.wp_dist = 32'd1000; end
      19: begin s.word = 32'hFFFF_FFFF; s.now = 32'd0; s.wp_dist = 32'hFFFF_FFFF; end
      default: begin s.word = 32'h8000_0064; s.now = 32'd0; s.wp_dist = 32'd700000; end
    endcase
    return s;
  endfunction

  task automatic random_phase(input int count, input bit with_pause);
    int burst;
    burst = $urandom_range(1, 40);
    for (int i = 0; i < count; i++) begin
      if (with_pause && i == count / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      send_sample(rand_sample());
      if (--burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Registers at their reset values first.
    random_phase(100, 1'b0);
    wait_idle();
    apply_setting(0);
    for (int k = 0; k < 21; k++) send_sample(directed_sample(k));
    for (int p = 1; p < 9; p++) begin
      wait_idle();
      apply_setting(p);
      random_phase(105, p == 4);
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d navigation samples under %0d register settings plus reset values.",
             samples_sent, settings_used);
    $display("Compared %0d target results against the prediction.", checked);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
